[hdl/ckms_pkg.sv]
// ============================================================================
// ckms_pkg: shared definitions of the capacitive key matrix scanner
// Matrix geometry, derived widths, the key store write word and the row
// limit function that both the scan logic and the checks rely on.
// ============================================================================
`default_nettype none

package ckms_pkg;

   // Matrix geometry.
   localparam int ROW_MUX_BITS = 3;
   localparam int COL_MUX_BITS = 3;
   localparam int COL_GROUPS   = 2;

   // Derived sizes.
   localparam int MUX_ROWS = 1 << ROW_MUX_BITS;
   localparam int MUX_COLS = 1 << COL_MUX_BITS;
   localparam int ALL_COLS = MUX_COLS * COL_GROUPS;
   localparam int COL_BITS = $clog2(ALL_COLS);
   localparam int CFG_BITS = 4;
   // Wide enough for the configured row count and for MUX_ROWS itself.
   localparam int LIM_BITS = (ROW_MUX_BITS + 1 > CFG_BITS) ? ROW_MUX_BITS + 1 : CFG_BITS;
   // Key store slots, addressed by row and column side by side.
   localparam int KEY_BITS  = ROW_MUX_BITS + COL_BITS;
   localparam int KEY_SLOTS = 1 << KEY_BITS;

   typedef logic [ROW_MUX_BITS-1:0] row_type;
   typedef logic [COL_BITS-1:0]     col_type;
   typedef logic [LIM_BITS-1:0]     lim_type;
   typedef logic [KEY_BITS-1:0]     key_idx_type;

   // Write request into the key store.
   typedef struct packed {
      logic    we;
      row_type row;
      col_type col;
      logic    data;
   } key_wr_type;

   // Effective row limit: zero counts as one, large values saturate.
   function automatic lim_type row_limit(input logic [CFG_BITS-1:0] rows);
      lim_type lim;
      lim = LIM_BITS'(rows);
      if (lim == '0) begin
         lim = LIM_BITS'(1);
      end
      if (lim > LIM_BITS'(MUX_ROWS)) begin
         lim = LIM_BITS'(MUX_ROWS);
      end
      return lim;
   endfunction

endpackage

`default_nettype wire

[hdl/ckms_ifs.sv]
// ============================================================================
// ckms channel interfaces
// Valid/ready channels for sense samples, scan results and the row count
// register write.
// ============================================================================
`default_nettype none

interface ckms_req_if;
   logic valid;
   logic ready;
   logic key_sensed;

   modport source (output valid, output key_sensed, input ready);
   modport sink   (input valid, input key_sensed, output ready);
endinterface

interface ckms_rsp_if;
   logic       valid;
   logic       ready;
   logic       change_valid;
   logic [2:0] change_row;
   logic [3:0] change_col;
   logic       change_pressed;
   logic [2:0] row_drive;
   logic [2:0] col_drive;
   logic [1:0] group_select;
   logic       hys_drive;
   logic       scan_done;

   modport source (output valid, output change_valid, output change_row,
                   output change_col, output change_pressed, output row_drive,
                   output col_drive, output group_select, output hys_drive,
                   output scan_done, input ready);
   modport sink   (input valid, input change_valid, input change_row,
                   input change_col, input change_pressed, input row_drive,
                   input col_drive, input group_select, input hys_drive,
                   input scan_done, output ready);
endinterface

interface ckms_csr_if;
   logic       valid;
   logic       ready;
   logic [3:0] rows_in_use;

   modport source (output valid, output rows_in_use, input ready);
   modport sink   (input valid, input rows_in_use, output ready);
endinterface

`default_nettype wire

[hdl/ckms_key_store.sv]
// ============================================================================
// ckms_key_store: pressed state of every key
// One bit per key in a memory with registered reads. The current key is
// read ahead at the position the scan moves to, the next key is
// read when a sample is accepted. Written flags, cleared by reset, make
// every key read as released until it is first written.
// ============================================================================
`default_nettype none

module ckms_key_store (
   input  wire                   clock,
   input  wire                   reset,
   input  ckms_pkg::key_wr_type  wr,
   input  ckms_pkg::row_type     cur_row,
   input  ckms_pkg::col_type     cur_col,
   input  logic                  nxt_en,
   input  ckms_pkg::row_type     nxt_row,
   input  ckms_pkg::col_type     nxt_col,
   output logic                  cur_bit,
   output logic                  nxt_bit
);

   logic                           key_mem [ckms_pkg::KEY_SLOTS];
   logic [ckms_pkg::KEY_SLOTS-1:0] written_ff, written_in;
   ckms_pkg::key_idx_type          wr_idx, cur_idx, nxt_idx;
   logic                           cur_hit, nxt_hit;
   logic                           cur_data_ff, cur_seen_ff;
   logic                           nxt_data_ff, nxt_seen_ff;

   assign wr_idx  = {wr.row, wr.col};
   assign cur_idx = {cur_row, cur_col};
   assign nxt_idx = {nxt_row, nxt_col};
   assign cur_hit = wr.we && (wr_idx == cur_idx);
   assign nxt_hit = wr.we && (wr_idx == nxt_idx);

   // A write marks its key as holding a stored level.
   always_comb begin
      written_in = written_ff;
      if (wr.we) begin
         written_in[wr_idx] = 1'b1;
      end
   end

   // Memory write and registered reads; a write to the read key passes through.
   always_ff @(posedge clock) begin
      if (wr.we) begin
         key_mem[wr_idx] <= wr.data;
      end
      if (cur_hit) begin
         cur_data_ff <= wr.data;
      end else begin
         cur_data_ff <= key_mem[cur_idx];
      end
      if (nxt_en) begin
         if (nxt_hit) begin
            nxt_data_ff <= wr.data;
         end else begin
            nxt_data_ff <= key_mem[nxt_idx];
         end
      end
   end

   // Written flags and their copies for the two read keys.
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff  <= '0;
         cur_seen_ff <= 1'b0;
         nxt_seen_ff <= 1'b0;
      end else begin
         written_ff  <= written_in;
         cur_seen_ff <= written_in[cur_idx];
         if (nxt_en) begin
            nxt_seen_ff <= written_in[nxt_idx];
         end
      end
   end

   assign cur_bit = cur_seen_ff & cur_data_ff;
   assign nxt_bit = nxt_seen_ff & nxt_data_ff;

endmodule

`default_nettype wire

[hdl/capacitive_key_matrix_scanner.sv]
// ============================================================================
// capacitive_key_matrix_scanner: capacitive key matrix scan engine
// Compares each sensed sample with the stored key state, reports changes
// and drives the mux codes and hysteresis level of the next position.
// ============================================================================
//
//   Channel    Direction  Word
//   req_chan   in         key_sensed: sensed level at the current position
//   rsp_chan   out        change report plus drives for the next position
//   csr_chan   in         rows_in_use: rows scanned in each column
//
// One sample is taken per clock while intake is not stalled; its result
// appears in the output register on the next cycle. The stored state of
// the current key is read ahead, so the compare, the store write and the
// position advance happen in the accepting cycle; the next key is read at
// acceptance, ready with the result. A held result stalls intake only when
// the sink is not ready in that cycle. Reset clears the written flags of the
// key store, the scan position and sets rows_in_use to 8; no clearing pass is needed.
// ============================================================================
`default_nettype none

module capacitive_key_matrix_scanner (
   input  wire         clock,
   input  wire         reset,
   ckms_req_if.sink    req_chan,
   ckms_rsp_if.source  rsp_chan,
   ckms_csr_if.sink    csr_chan
);

   localparam int LB = ckms_pkg::LIM_BITS;
   localparam int CB = ckms_pkg::COL_BITS;

   // Scan state and configuration.
   ckms_pkg::row_type            scan_row_ff, scan_row_in;
   ckms_pkg::col_type            scan_col_ff, scan_col_in;
   logic [ckms_pkg::CFG_BITS-1:0] rows_ff, rows_in;
   ckms_pkg::lim_type            limit;

   // Step results.
   logic                 accept;
   logic                 cur_bit, nxt_bit;
   logic                 changed;
   ckms_pkg::row_type    row_n;
   ckms_pkg::col_type    col_n;
   logic                 done;
   ckms_pkg::lim_type    row_inc;
   logic [CB:0]          col_inc;
   ckms_pkg::col_type    group;
   ckms_pkg::key_wr_type wr;

   // Output register.
   logic       rsp_valid_ff;
   logic       chg_valid_ff, chg_press_ff, done_ff;
   logic [2:0] chg_row_ff, row_drv_ff, col_drv_ff;
   logic [3:0] chg_col_ff;
   logic [1:0] grp_sel_ff;

   // Intake continues whenever the output register is free or draining.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign limit          = ckms_pkg::row_limit(rows_ff);

   // Position advance: rows inside, columns outside.
   always_comb begin
      row_inc = LB'(scan_row_ff) + LB'(1);
      col_inc = (CB + 1)'(scan_col_ff) + (CB + 1)'(1);
      row_n   = scan_row_ff;
      col_n   = scan_col_ff;
      done    = 1'b0;
      if (row_inc >= limit) begin
         row_n = '0;
         if (col_inc >= (CB + 1)'(ckms_pkg::ALL_COLS)) begin
            col_n = '0;
            done  = 1'b1;
         end else begin
            col_n = col_inc[CB-1:0];
         end
      end else begin
         row_n = row_inc[ckms_pkg::ROW_MUX_BITS-1:0];
      end
   end

   assign changed = (cur_bit != req_chan.key_sensed);
   assign group   = col_n >> ckms_pkg::COL_MUX_BITS;

   always_comb begin
      wr.we   = accept && changed;
      wr.row  = scan_row_ff;
      wr.col  = scan_col_ff;
      wr.data = req_chan.key_sensed;
   end

   // The current key is read at the position the scan moves to.
   ckms_key_store u_store (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .cur_row (scan_row_in),
      .cur_col (scan_col_in),
      .nxt_en  (accept),
      .nxt_row (row_n),
      .nxt_col (col_n),
      .cur_bit (cur_bit),
      .nxt_bit (nxt_bit)
   );

   // Next scan state; a row count write pulls an out-of-range row to zero.
   always_comb begin
      scan_row_in = scan_row_ff;
      scan_col_in = scan_col_ff;
      rows_in     = rows_ff;
      if (accept) begin
         scan_row_in = row_n;
         scan_col_in = col_n;
      end
      if (csr_chan.valid && csr_chan.ready) begin
         rows_in = csr_chan.rows_in_use;
         if (LB'(scan_row_in) >= ckms_pkg::row_limit(csr_chan.rows_in_use)) begin
            scan_row_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_row_ff <= '0;
         scan_col_ff <= '0;
         rows_ff     <= ckms_pkg::CFG_BITS'(8);
      end else begin
         scan_row_ff <= scan_row_in;
         scan_col_ff <= scan_col_in;
         rows_ff     <= rows_in;
      end
   end

   // Result valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result word; change fields read zero when nothing changed.
   always_ff @(posedge clock) begin
      if (accept) begin
         chg_valid_ff <= changed;
         chg_row_ff   <= changed ? 3'(scan_row_ff) : 3'd0;
         chg_col_ff   <= changed ? 4'(scan_col_ff) : 4'd0;
         chg_press_ff <= changed & req_chan.key_sensed;
         row_drv_ff   <= 3'(row_n);
         col_drv_ff   <= 3'(col_n[ckms_pkg::COL_MUX_BITS-1:0]);
         grp_sel_ff   <= {group == CB'(1), group == '0};
         done_ff      <= done;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.change_valid   = chg_valid_ff;
   assign rsp_chan.change_row     = chg_row_ff;
   assign rsp_chan.change_col     = chg_col_ff;
   assign rsp_chan.change_pressed = chg_press_ff;
   assign rsp_chan.row_drive      = row_drv_ff;
   assign rsp_chan.col_drive      = col_drv_ff;
   assign rsp_chan.group_select   = grp_sel_ff;
   assign rsp_chan.hys_drive      = nxt_bit;
   assign rsp_chan.scan_done      = done_ff;

   // The scan row never sits at or beyond the active row limit.
   a_row_in_limit: assert property (@(posedge clock) disable iff (reset)
      LB'(scan_row_ff) < limit)
      else $error("scan row beyond row limit");

   // An accepted sample always leaves a result in the output register.
   a_accept_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted sample produced no result");

   // The end of a full scan points the drives back at the first position.
   a_done_wraps: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && done_ff) |->
         (row_drv_ff == 3'd0 && col_drv_ff == 3'd0 && grp_sel_ff == 2'b01))
      else $error("scan end did not wrap the position");

   // Without a change, the change fields are all zero.
   a_quiet_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !chg_valid_ff) |->
         (chg_row_ff == 3'd0 && chg_col_ff == 4'd0 && !chg_press_ff))
      else $error("change fields set without a change");

   // A detected change is always reported, with the pressed flag equal to the sample.
   a_change_written: assert property (@(posedge clock) disable iff (reset)
      (accept && changed) |=> (chg_valid_ff && chg_press_ff == $past(req_chan.key_sensed)))
      else $error("change report does not match the sample");

endmodule

`default_nettype wire
